>>> design/gled_pkg.sv
// ----------------------------------------------------------------------------
// gled_pkg
// Shared constants and types of the grid local extrema detector.
// ----------------------------------------------------------------------------
package gled_pkg;

	localparam int MAX_DIM_DEFAULT    = 64;
	localparam int VALUE_BITS_DEFAULT = 8;
	localparam int CFG_BITS           = 7;
	localparam int CFG_INDEX_BITS     = 1;
	localparam int RESET_DIM          = 20;
	localparam int MAX_RESULTS        = 4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REGION_CORNER   = 2'd0,
		REGION_EDGE     = 2'd1,
		REGION_INTERIOR = 2'd2
	} region_t;

	typedef struct packed {
		logic    is_min;
		logic    is_max;
		region_t region;
	} cell_flags_t;

endpackage

>>> design/gled_line_store.sv
// ----------------------------------------------------------------------------
// gled_line_store
// Two line memories holding the two rows above the current one.
// ----------------------------------------------------------------------------
module gled_line_store #(
	parameter int MAX_DIM    = gled_pkg::MAX_DIM_DEFAULT,
	parameter int VALUE_BITS = gled_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_DIM)-1:0]   rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_DIM)-1:0]   wr_addr,
	input  logic [VALUE_BITS-1:0]        wr_value,
	output logic [VALUE_BITS-1:0]        older_rd,
	output logic [VALUE_BITS-1:0]        recent_rd
);

	logic [VALUE_BITS-1:0] older_mem  [MAX_DIM];
	logic [VALUE_BITS-1:0] recent_mem [MAX_DIM];

	// Read on transfer; the write of the same item follows once it leaves
	// stage one, so the read data still holds the old recent row for older.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			older_rd  <= older_mem[rd_addr];
			recent_rd <= recent_mem[rd_addr];
		end
		if (wr_en) begin
			older_mem[wr_addr]  <= recent_rd;
			recent_mem[wr_addr] <= wr_value;
		end
	end

endmodule

>>> design/gled_window_judge.sv
// ----------------------------------------------------------------------------
// gled_window_judge
// 3x3 window registers and the neighbour compares for up to four cells.
// ----------------------------------------------------------------------------
module gled_window_judge #(
	parameter int MAX_DIM    = gled_pkg::MAX_DIM_DEFAULT,
	parameter int VALUE_BITS = gled_pkg::VALUE_BITS_DEFAULT,
	localparam int PW        = $clog2(MAX_DIM)
) (
	input  logic                                      clk,
	input  logic                                      shift,
	input  logic [VALUE_BITS-1:0]                     older_col,
	input  logic [VALUE_BITS-1:0]                     recent_col,
	input  logic [VALUE_BITS-1:0]                     new_col,
	input  logic [PW-1:0]                             row_s1,
	input  logic [PW-1:0]                             col_s1,
	input  logic [PW-1:0]                             last_row,
	input  logic [PW-1:0]                             last_col,
	output logic [gled_pkg::MAX_RESULTS-1:0]          res_valid,
	output logic [gled_pkg::MAX_RESULTS-1:0][PW-1:0]  res_row,
	output logic [gled_pkg::MAX_RESULTS-1:0][PW-1:0]  res_col,
	output logic [gled_pkg::MAX_RESULTS-1:0][VALUE_BITS-1:0] res_value,
	output gled_pkg::cell_flags_t [gled_pkg::MAX_RESULTS-1:0] res_flags
);

	logic [8:0][VALUE_BITS-1:0] win_q;
	logic [8:0][VALUE_BITS-1:0] win_d;
	logic [PW-1:0]              row_m1;
	logic [PW-1:0]              col_m1;

	function automatic gled_pkg::cell_flags_t judge_cell(
		input logic [8:0][VALUE_BITS-1:0] w,
		input int                         wr,
		input int                         wc,
		input logic                       top_ok,
		input logic                       bot_ok,
		input logic                       left_ok,
		input logic                       right_ok
	);
		gled_pkg::cell_flags_t f;
		logic [VALUE_BITS-1:0] ctr;
		logic                  row_ok;
		logic                  col_ok;
		logic                  rb;
		logic                  cb;
		int                    ar;
		int                    ac;
		ctr      = w[wr*3+wc];
		f.is_min = 1'b1;
		f.is_max = 1'b1;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				ar     = wr + dr;
				ac     = wc + dc;
				row_ok = (dr < 0) ? top_ok : ((dr > 0) ? bot_ok : 1'b1);
				col_ok = (dc < 0) ? left_ok : ((dc > 0) ? right_ok : 1'b1);
				if (!(dr == 0 && dc == 0) && row_ok && col_ok &&
				    ar >= 0 && ar <= 2 && ac >= 0 && ac <= 2) begin
					if (w[ar*3+ac] < ctr) f.is_min = 1'b0;
					if (w[ar*3+ac] > ctr) f.is_max = 1'b0;
				end
			end
		end
		rb = !top_ok || !bot_ok;
		cb = !left_ok || !right_ok;
		if (rb && cb)      f.region = gled_pkg::REGION_CORNER;
		else if (rb || cb) f.region = gled_pkg::REGION_EDGE;
		else               f.region = gled_pkg::REGION_INTERIOR;
		return f;
	endfunction

	// Window after this item's shift: drop the left column, append the new one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_d[i*3+0] = win_q[i*3+1];
			win_d[i*3+1] = win_q[i*3+2];
		end
		win_d[2] = older_col;
		win_d[5] = recent_col;
		win_d[8] = new_col;
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			win_q <= win_d;
		end
	end

	assign row_m1 = row_s1 - PW'(1);
	assign col_m1 = col_s1 - PW'(1);

	always_comb begin
		res_valid[0] = (row_s1 != '0) && (col_s1 != '0);
		res_valid[1] = (row_s1 != '0) && (col_s1 == last_col);
		res_valid[2] = (row_s1 == last_row) && (col_s1 != '0);
		res_valid[3] = (row_s1 == last_row) && (col_s1 == last_col);

		res_row[0] = row_m1;  res_col[0] = col_m1;  res_value[0] = win_d[4];
		res_row[1] = row_m1;  res_col[1] = col_s1;  res_value[1] = win_d[5];
		res_row[2] = row_s1;  res_col[2] = col_m1;  res_value[2] = win_d[7];
		res_row[3] = row_s1;  res_col[3] = col_s1;  res_value[3] = win_d[8];

		res_flags[0] = judge_cell(win_d, 1, 1, row_m1 != '0, row_m1 != last_row,
		                          col_m1 != '0, col_m1 != last_col);
		res_flags[1] = judge_cell(win_d, 1, 2, row_m1 != '0, row_m1 != last_row,
		                          col_s1 != '0, col_s1 != last_col);
		res_flags[2] = judge_cell(win_d, 2, 1, row_s1 != '0, row_s1 != last_row,
		                          col_m1 != '0, col_m1 != last_col);
		res_flags[3] = judge_cell(win_d, 2, 2, row_s1 != '0, row_s1 != last_row,
		                          col_s1 != '0, col_s1 != last_col);
	end

endmodule

>>> design/gled_result_queue.sv
// ----------------------------------------------------------------------------
// gled_result_queue
// Packs the results of one item into a small queue and hands them out in order.
// ----------------------------------------------------------------------------
module gled_result_queue #(
	parameter int MAX_DIM    = gled_pkg::MAX_DIM_DEFAULT,
	parameter int VALUE_BITS = gled_pkg::VALUE_BITS_DEFAULT,
	localparam int PW        = $clog2(MAX_DIM)
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      load,
	input  logic [gled_pkg::MAX_RESULTS-1:0]          res_valid,
	input  logic [gled_pkg::MAX_RESULTS-1:0][PW-1:0]  res_row,
	input  logic [gled_pkg::MAX_RESULTS-1:0][PW-1:0]  res_col,
	input  logic [gled_pkg::MAX_RESULTS-1:0][VALUE_BITS-1:0] res_value,
	input  gled_pkg::cell_flags_t [gled_pkg::MAX_RESULTS-1:0] res_flags,
	output logic                                      free,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [PW-1:0]                             cell_row,
	output logic [PW-1:0]                             cell_col,
	output logic [VALUE_BITS-1:0]                     center_value,
	output logic                                      is_minimum,
	output logic                                      is_maximum,
	output logic [1:0]                                region,
	output logic                                      last_of_run
);

	localparam int NR = gled_pkg::MAX_RESULTS;

	logic [2:0]                                cnt_q, cnt_d;
	logic [NR-1:0][PW-1:0]                     row_q, row_d;
	logic [NR-1:0][PW-1:0]                     col_q, col_d;
	logic [NR-1:0][VALUE_BITS-1:0]             value_q, value_d;
	gled_pkg::cell_flags_t [NR-1:0]            flags_q, flags_d;
	logic                                      out_fire;

	assign out_valid = (cnt_q != 3'd0);
	assign out_fire  = out_valid && out_ready;
	assign free      = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready);

	assign cell_row     = row_q[0];
	assign cell_col     = col_q[0];
	assign center_value = value_q[0];
	assign is_minimum   = flags_q[0].is_min;
	assign is_maximum   = flags_q[0].is_max;
	assign region       = flags_q[0].region;
	assign last_of_run  = (cnt_q == 3'd1);

	always_comb begin
		logic [2:0] n;
		cnt_d   = cnt_q;
		row_d   = row_q;
		col_d   = col_q;
		value_d = value_q;
		flags_d = flags_q;
		n       = 3'd0;
		// advance the queue head on each transfer
		if (out_fire) begin
			for (int i = 0; i < NR - 1; i++) begin
				row_d[i]   = row_q[i+1];
				col_d[i]   = col_q[i+1];
				value_d[i] = value_q[i+1];
				flags_d[i] = flags_q[i+1];
			end
			cnt_d = cnt_q - 3'd1;
		end
		// pack the valid results of a new item in their fixed order
		if (load) begin
			for (int i = 0; i < NR; i++) begin
				if (res_valid[i]) begin
					row_d[n[1:0]]   = res_row[i];
					col_d[n[1:0]]   = res_col[i];
					value_d[n[1:0]] = res_value[i];
					flags_d[n[1:0]] = res_flags[i];
					n = n + 3'd1;
				end
			end
			cnt_d = n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		row_q   <= row_d;
		col_q   <= col_d;
		value_q <= value_d;
		flags_q <= flags_d;
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready))
		else $error("result queue loaded while still holding results");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(NR))
		else $error("result queue count above its depth");

	a_hold_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_q[0]) &&
			$stable(col_q[0]) && $stable(value_q[0]) && $stable(flags_q[0]))
		else $error("waiting result changed before its transfer");

endmodule

>>> design/grid_local_extrema_detector.sv
// ----------------------------------------------------------------------------
// grid_local_extrema_detector
// Streams a grid in raster order and flags each cell as 3x3 local min/max.
// ----------------------------------------------------------------------------
// Flow: an item is registered in stage one, then, once the result queue is free,
//   its results are loaded into the queue, which offers them. Results concern the
//   cell one row and one cell behind it; row ends and the last row add nearer cells.
// Throughput: one item per cycle while the result queue is free; an item with
//   several results (row ends and the last row) holds the input while the
//   single-result output port of the result queue hands them out.
// Reset: counters at row 0 column 0, grid 20 x 20; line memories not cleared.
// ----------------------------------------------------------------------------
module grid_local_extrema_detector #(
	parameter int MAX_DIM    = gled_pkg::MAX_DIM_DEFAULT,
	parameter int VALUE_BITS = gled_pkg::VALUE_BITS_DEFAULT,
	localparam int PW        = $clog2(MAX_DIM)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [gled_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gled_pkg::CFG_BITS-1:0]       cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [VALUE_BITS-1:0]               cell_value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [PW-1:0]                       cell_row,
	output logic [PW-1:0]                       cell_col,
	output logic [VALUE_BITS-1:0]               center_value,
	output logic                                is_minimum,
	output logic                                is_maximum,
	output logic [1:0]                          region,
	output logic                                last_of_run
);

	localparam int DW   = $clog2(MAX_DIM + 1);
	localparam int CMPW = (gled_pkg::CFG_BITS > DW) ? gled_pkg::CFG_BITS : DW;
	localparam int RESET_LAST =
		((gled_pkg::RESET_DIM > MAX_DIM) ? MAX_DIM : gled_pkg::RESET_DIM) - 1;

	localparam int NR = gled_pkg::MAX_RESULTS;

	// Grid size is kept as the index of the last row and column, clamped to
	// the range 2..MAX_DIM when written.
	logic [PW-1:0] last_row_q;
	logic [PW-1:0] last_col_q;
	logic [PW-1:0] row_q;
	logic [PW-1:0] col_q;

	// position of the item on the input side, after the out-of-grid fix
	logic          out_of_grid;
	logic [PW-1:0] row_in;
	logic [PW-1:0] col_in;
	logic          in_fire;

	// stage one: line memory read data arrives here
	logic                  s1_valid_q;
	logic [VALUE_BITS-1:0] value_s1;
	logic [PW-1:0]         row_s1;
	logic [PW-1:0]         col_s1;
	logic                  s1_go;

	logic [VALUE_BITS-1:0] older_rd;
	logic [VALUE_BITS-1:0] recent_rd;

	logic [NR-1:0]                  res_valid;
	logic [NR-1:0][PW-1:0]          res_row;
	logic [NR-1:0][PW-1:0]          res_col;
	logic [NR-1:0][VALUE_BITS-1:0]  res_value;
	gled_pkg::cell_flags_t [NR-1:0] res_flags;
	logic                           q_free;

	function automatic logic [PW-1:0] last_index(input logic [gled_pkg::CFG_BITS-1:0] v);
		logic [CMPW-1:0] wv;
		wv = CMPW'(v);
		if (wv < CMPW'(2))            return PW'(1);
		else if (wv > CMPW'(MAX_DIM)) return PW'(MAX_DIM - 1);
		else                          return PW'(wv - CMPW'(1));
	endfunction

	assign out_of_grid = (row_q > last_row_q) || (col_q > last_col_q);
	assign row_in      = out_of_grid ? '0 : row_q;
	assign col_in      = out_of_grid ? '0 : col_q;

	// Stage one leaves once the queue can take its results; an item with no
	// result still leaves, to write the lines and shift the window.
	assign s1_go    = s1_valid_q && q_free;
	assign in_ready = !s1_valid_q || s1_go;
	assign in_fire  = in_valid && in_ready;

	// Counters and configuration. A write to either size register restarts
	// the frame, even when the value is unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= PW'(RESET_LAST);
			last_col_q <= PW'(RESET_LAST);
			row_q      <= '0;
			col_q      <= '0;
		end else begin
			if (in_fire) begin
				if (col_in == last_col_q) begin
					col_q <= '0;
					row_q <= (row_in == last_row_q) ? '0 : row_in + PW'(1);
				end else begin
					col_q <= col_in + PW'(1);
					row_q <= row_in;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					gled_pkg::REG_GRID_ROWS: begin
						last_row_q <= last_index(cfg_data);
						row_q      <= '0;
						col_q      <= '0;
					end
					gled_pkg::REG_GRID_COLS: begin
						last_col_q <= last_index(cfg_data);
						row_q      <= '0;
						col_q      <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Stage one valid: set on transfer, drop when the item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_s1 <= cell_value;
			row_s1   <= row_in;
			col_s1   <= col_in;
		end
	end

	// Line memories: read at the transfer, write back when stage one leaves.
	// Consecutive items of one frame sit in different columns (a grid is at least
	// two wide), so there a read never meets a pending write to the same entry.
	gled_line_store #(
		.MAX_DIM    (MAX_DIM),
		.VALUE_BITS (VALUE_BITS)
	) u_line_store (
		.clk       (clk),
		.rd_en     (in_fire),
		.rd_addr   (col_in),
		.wr_en     (s1_go),
		.wr_addr   (col_s1),
		.wr_value  (value_s1),
		.older_rd  (older_rd),
		.recent_rd (recent_rd)
	);

	// Window shift and the compares for the four cells this item may finish.
	gled_window_judge #(
		.MAX_DIM    (MAX_DIM),
		.VALUE_BITS (VALUE_BITS)
	) u_window_judge (
		.clk        (clk),
		.shift      (s1_go),
		.older_col  (older_rd),
		.recent_col (recent_rd),
		.new_col    (value_s1),
		.row_s1     (row_s1),
		.col_s1     (col_s1),
		.last_row   (last_row_q),
		.last_col   (last_col_q),
		.res_valid  (res_valid),
		.res_row    (res_row),
		.res_col    (res_col),
		.res_value  (res_value),
		.res_flags  (res_flags)
	);

	// Result queue: holds the results of one item and drives the outputs.
	gled_result_queue #(
		.MAX_DIM    (MAX_DIM),
		.VALUE_BITS (VALUE_BITS)
	) u_result_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (s1_go),
		.res_valid    (res_valid),
		.res_row      (res_row),
		.res_col      (res_col),
		.res_value    (res_value),
		.res_flags    (res_flags),
		.free         (q_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.center_value (center_value),
		.is_minimum   (is_minimum),
		.is_maximum   (is_maximum),
		.region       (region),
		.last_of_run  (last_of_run)
	);

	a_counters_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= last_row_q) && (col_q <= last_col_q))
		else $error("raster counters outside the grid");

	a_fire_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> s1_valid_q)
		else $error("transferred item did not reach stage one");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !q_free |=> s1_valid_q && $stable(col_s1) && $stable(row_s1))
		else $error("stage one item lost while the queue was busy");

endmodule
